FILE: rtl/core/assert_macros.svh
// Shared assertion helpers. Each use expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sswd_pkg.sv
package sswd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 2'd2;

  // Register widths
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DECIM_W    = 13;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned THR_W      = LEVEL_W + 1;

  // Reset values
  localparam logic [DECIM_W-1:0]        DECIM_RST      = 13'd16;
  localparam logic signed [LEVEL_W-1:0] HIGH_LEVEL_RST = 16'sd16384;
  localparam logic signed [LEVEL_W-1:0] LOW_LEVEL_RST  = 16'sd0;

  // Finished windows that may wait between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

FILE: rtl/core/switched_sync_detector.sv
// Switched synchronous detector with decimation. Each accepted item is a pair
// of a data sample and a reference sample; the reference is compared with the
// threshold high_level - low_level (formed at full precision) and the data
// sample is summed into the low class when the reference is below it, into the
// high class otherwise. After decim items (0 acts as 1, values above MAX_WINDOW
// clamp to it) one result carries low-class mean minus high-class mean, each
// mean truncated toward zero and 0 for an empty class; all sums and counts then
// clear. Register writes never clear the running window. The front end takes
// one item per cycle. Each finished window goes into a two-entry queue and the
// back end turns it into a result with a shared bit-serial divider: one
// quotient bit a cycle, SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW + 1) steps per
// division. Input stalls only when a window closes while two earlier windows
// still wait in the queue. No clearing pass follows reset.
module switched_sync_detector #(
  parameter int unsigned MAX_WINDOW  = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [sswd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sswd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // sample pair input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      data_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]      ref_sample_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_BITS:0]        mean_difference_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned REC_W = 2 * (SUM_W + CNT_W);
  localparam int unsigned OUT_W = SAMPLE_BITS + 1;

  logic             push;
  logic             push_ready;
  logic [REC_W-1:0] push_rec;
  logic             rec_valid;
  logic [REC_W-1:0] rec_head;
  logic             pop;

  // Front: classify and accumulate, hand each closed window to the queue
  sswd_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .REC_W      (REC_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_sample_i(data_sample_i),
    .ref_sample_i (ref_sample_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .rec_o        (push_rec)
  );

  // Queue of finished windows: sums and counts of both classes
  sswd_fifo #(
    .WIDTH(REC_W),
    .DEPTH(sswd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     (push_rec),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .valid_o     (rec_valid),
    .rdata_o     (rec_head)
  );

  // Back: one division per non-empty class, then the registered result
  sswd_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .REC_W      (REC_W),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (rec_valid),
    .rec_i            (rec_head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mean_difference_o(mean_difference_o)
  );

endmodule

FILE: rtl/core/sswd_fifo.sv
module sswd_fifo #(
  parameter int unsigned WIDTH = 84,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o      = (count_q != '0);
  assign rdata_o      = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/sswd_front.sv
`include "assert_macros.svh"

module sswd_front #(
  parameter int unsigned MAX_WINDOW  = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = $clog2(MAX_WINDOW + 1),
  parameter int unsigned SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int unsigned REC_W       = 2 * (SUM_W + CNT_W)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sswd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sswd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      data_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]      ref_sample_i,
  output logic                               push_o,
  input  logic                               push_ready_i,
  output logic [REC_W-1:0]                   rec_o
);

  localparam int unsigned CMP_W =
    (SAMPLE_BITS > sswd_pkg::THR_W) ? SAMPLE_BITS : sswd_pkg::THR_W;

  logic [sswd_pkg::DECIM_W-1:0]        decim_q;
  logic signed [sswd_pkg::LEVEL_W-1:0] high_level_q;
  logic signed [sswd_pkg::LEVEL_W-1:0] low_level_q;

  logic signed [SUM_W-1:0] low_sum_q, low_sum_d, high_sum_q, high_sum_d;
  logic signed [SUM_W-1:0] low_sum_n, high_sum_n;
  logic [CNT_W-1:0]        low_cnt_q, low_cnt_d, high_cnt_q, high_cnt_d;
  logic [CNT_W-1:0]        low_cnt_n, high_cnt_n;
  logic [CNT_W-1:0]        win_q, win_d, win_n;

  logic signed [sswd_pkg::THR_W-1:0] threshold;
  logic signed [CMP_W-1:0]           thr_ext;
  logic signed [CMP_W-1:0]           ref_ext;
  logic signed [SUM_W-1:0]           data_ext;
  logic                              is_low;
  logic [31:0]                       limit;
  logic                              close;
  logic                              accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q      <= sswd_pkg::DECIM_RST;
      high_level_q <= sswd_pkg::HIGH_LEVEL_RST;
      low_level_q  <= sswd_pkg::LOW_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sswd_pkg::REG_DECIM:      decim_q      <= cfg_wdata_i[sswd_pkg::DECIM_W-1:0];
        sswd_pkg::REG_HIGH_LEVEL: high_level_q <= cfg_wdata_i[sswd_pkg::LEVEL_W-1:0];
        sswd_pkg::REG_LOW_LEVEL:  low_level_q  <= cfg_wdata_i[sswd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify against the full-precision threshold
  assign threshold = sswd_pkg::THR_W'(high_level_q) - sswd_pkg::THR_W'(low_level_q);
  assign thr_ext   = CMP_W'(threshold);
  assign ref_ext   = CMP_W'(ref_sample_i);
  assign is_low    = (ref_ext < thr_ext);
  assign data_ext  = SUM_W'(data_sample_i);

  // Window length: zero acts as one, large values clamp
  always_comb begin
    if (decim_q == '0) begin
      limit = 32'd1;
    end else if (32'(decim_q) > 32'(MAX_WINDOW)) begin
      limit = 32'(MAX_WINDOW);
    end else begin
      limit = 32'(decim_q);
    end
  end

  assign win_n      = win_q + CNT_W'(1);
  assign close      = (32'(win_n) >= limit);
  assign in_ready_o = !close || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && close;

  assign low_sum_n  = is_low ? low_sum_q + data_ext : low_sum_q;
  assign high_sum_n = is_low ? high_sum_q : high_sum_q + data_ext;
  assign low_cnt_n  = is_low ? low_cnt_q + CNT_W'(1) : low_cnt_q;
  assign high_cnt_n = is_low ? high_cnt_q : high_cnt_q + CNT_W'(1);
  assign rec_o      = {low_sum_n, low_cnt_n, high_sum_n, high_cnt_n};

  always_comb begin
    low_sum_d  = low_sum_q;
    high_sum_d = high_sum_q;
    low_cnt_d  = low_cnt_q;
    high_cnt_d = high_cnt_q;
    win_d      = win_q;
    if (accept) begin
      if (close) begin
        low_sum_d  = '0;
        high_sum_d = '0;
        low_cnt_d  = '0;
        high_cnt_d = '0;
        win_d      = '0;
      end else begin
        low_sum_d  = low_sum_n;
        high_sum_d = high_sum_n;
        low_cnt_d  = low_cnt_n;
        high_cnt_d = high_cnt_n;
        win_d      = win_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_sum_q  <= '0;
      high_sum_q <= '0;
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
      win_q      <= '0;
    end else begin
      low_sum_q  <= low_sum_d;
      high_sum_q <= high_sum_d;
      low_cnt_q  <= low_cnt_d;
      high_cnt_q <= high_cnt_d;
      win_q      <= win_d;
    end
  end

  `ASSERT_HOLDS(a_cnt_split, (low_cnt_q + high_cnt_q) == win_q, "class counts disagree with window count")
  `ASSERT_HOLDS(a_win_bound, win_q < CNT_W'(MAX_WINDOW), "window count past its maximum")
  `ASSERT_IMPLIES(a_push_room, push_o, push_ready_i, "window closed into a full queue")

endmodule

FILE: rtl/core/sswd_div.sv
module sswd_div #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic              fits;

  // One restoring step a cycle: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = !trial[DEN_W];

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/sswd_back.sv
`include "assert_macros.svh"

module sswd_back #(
  parameter int unsigned MAX_WINDOW  = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = $clog2(MAX_WINDOW + 1),
  parameter int unsigned SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int unsigned REC_W       = 2 * (SUM_W + CNT_W),
  parameter int unsigned OUT_W       = SAMPLE_BITS + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rec_valid_i,
  input  logic [REC_W-1:0]        rec_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] mean_difference_o
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_LOW       = 3'd1;
  localparam logic [2:0] ST_LOW_WAIT  = 3'd2;
  localparam logic [2:0] ST_HIGH      = 3'd3;
  localparam logic [2:0] ST_HIGH_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT      = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [SUM_W-1:0] low_sum, high_sum;
  logic [CNT_W-1:0] low_cnt, high_cnt;
  logic [SUM_W-1:0] low_mag, high_mag;
  logic [OUT_W-1:0] mean_low_q, mean_low_d, mean_high_q, mean_high_d;
  logic [OUT_W-1:0] quo_trunc, quo_neg;
  logic [OUT_W-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             div_start;
  logic [SUM_W-1:0] div_num;
  logic [CNT_W-1:0] div_den;
  logic             div_busy, div_done;
  logic [SUM_W-1:0] div_quo;

  // Head of the queue stays in place until its result is loaded
  assign {low_sum, low_cnt, high_sum, high_cnt} = rec_i;

  assign low_mag  = low_sum[SUM_W-1] ? SUM_W'(0) - low_sum : low_sum;
  assign high_mag = high_sum[SUM_W-1] ? SUM_W'(0) - high_sum : high_sum;

  assign quo_trunc = div_quo[OUT_W-1:0];
  assign quo_neg   = OUT_W'(0) - quo_trunc;

  sswd_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    mean_low_d  = mean_low_q;
    mean_high_d = mean_high_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;
    div_num     = low_mag;
    div_den     = low_cnt;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (rec_valid_i) begin
          state_d = ST_LOW;
        end
      end
      ST_LOW: begin
        if (low_cnt == '0) begin
          mean_low_d = '0;
          state_d    = ST_HIGH;
        end else begin
          div_start = 1'b1;
          state_d   = ST_LOW_WAIT;
        end
      end
      ST_LOW_WAIT: begin
        if (div_done) begin
          mean_low_d = low_sum[SUM_W-1] ? quo_neg : quo_trunc;
          state_d    = ST_HIGH;
        end
      end
      ST_HIGH: begin
        div_num = high_mag;
        div_den = high_cnt;
        if (high_cnt == '0) begin
          mean_high_d = '0;
          state_d     = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_HIGH_WAIT;
        end
      end
      ST_HIGH_WAIT: begin
        div_num = high_mag;
        div_den = high_cnt;
        if (div_done) begin
          mean_high_d = high_sum[SUM_W-1] ? quo_neg : quo_trunc;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the output register once it is free, then drop the window
        if (!out_valid_q || out_ready_i) begin
          out_d       = mean_low_q - mean_high_q;
          out_valid_d = 1'b1;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_low_q  <= mean_low_d;
    mean_high_q <= mean_high_d;
    out_q       <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign mean_difference_o = out_q;

  `ASSERT_IMPLIES(a_start_idle, div_start, !div_busy, "divider restarted while busy")
  `ASSERT_IMPLIES(a_wait_low, state_q == ST_LOW_WAIT, div_busy || div_done, "low wait without division")
  `ASSERT_IMPLIES(a_wait_high, state_q == ST_HIGH_WAIT, div_busy || div_done, "high wait without division")
  `ASSERT_IMPLIES(a_pop_head, pop_o, rec_valid_i, "pop from an empty queue")

endmodule

FILE: verif/sswd_window_checker.sv
module sswd_window_checker
  import sswd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [15:0]           data_sample_i,
  input  logic signed [15:0]           ref_sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [16:0]           mean_difference_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = SAMPLE_W + 1;
  localparam int unsigned SUM_W    = 29;
  localparam int unsigned CNT_W    = 13;

  logic [DECIM_W-1:0]        decim_q;
  logic signed [LEVEL_W-1:0] high_level_q;
  logic signed [LEVEL_W-1:0] low_level_q;
  logic signed [SUM_W-1:0]   low_sum_q;
  logic signed [SUM_W-1:0]   high_sum_q;
  logic [CNT_W-1:0]          low_cnt_q;
  logic [CNT_W-1:0]          high_cnt_q;
  logic [CNT_W-1:0]          window_cnt_q;

  // Mean differences of closed windows, oldest first
  logic signed [OUT_W-1:0]   mean_diff_q[$];

  // Sort one pair into its class; close the window when it is full.
  task automatic take_pair(input logic signed [SAMPLE_W-1:0] data,
                           input logic signed [SAMPLE_W-1:0] refv);
    logic signed [THR_W-1:0] threshold;
    int unsigned             window_len;
    longint                  low_mean;
    longint                  high_mean;
    threshold = {high_level_q[LEVEL_W-1], high_level_q}
              - {low_level_q[LEVEL_W-1], low_level_q};
    if (decim_q == '0)
      window_len = 1;
    else if (decim_q > MAX_WINDOW)
      window_len = MAX_WINDOW;
    else
      window_len = decim_q;

    if ($signed({refv[SAMPLE_W-1], refv}) < threshold) begin
      low_sum_q = low_sum_q + data;
      low_cnt_q = low_cnt_q + 1'b1;
    end else begin
      high_sum_q = high_sum_q + data;
      high_cnt_q = high_cnt_q + 1'b1;
    end
    window_cnt_q = window_cnt_q + 1'b1;

    if (window_cnt_q >= window_len) begin
      low_mean  = (low_cnt_q == '0) ? 0 : longint'(low_sum_q) / longint'(low_cnt_q);
      high_mean = (high_cnt_q == '0) ? 0 : longint'(high_sum_q) / longint'(high_cnt_q);
      mean_diff_q.push_back(OUT_W'(low_mean - high_mean));
      low_sum_q    = '0;
      high_sum_q   = '0;
      low_cnt_q    = '0;
      high_cnt_q   = '0;
      window_cnt_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [OUT_W-1:0] want;
    if (!rst_ni) begin
      decim_q      = DECIM_RST;
      high_level_q = HIGH_LEVEL_RST;
      low_level_q  = LOW_LEVEL_RST;
      low_sum_q    = '0;
      high_sum_q   = '0;
      low_cnt_q    = '0;
      high_cnt_q   = '0;
      window_cnt_q = '0;
      mean_diff_q.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DECIM:      decim_q      = cfg_wdata_i[DECIM_W-1:0];
          REG_HIGH_LEVEL: high_level_q = cfg_wdata_i;
          REG_LOW_LEVEL:  low_level_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      // check results before adding the window this edge may close
      if (out_valid_i && out_ready_i) begin
        if (mean_diff_q.size() == 0) begin
          $display("%0t: mean difference expected none, got %0d", $time, mean_difference_i);
          fail_count_o++;
        end else begin
          want = mean_diff_q.pop_front();
          if (mean_difference_i !== want) begin
            $display("%0t: mean difference expected %0d, got %0d",
                     $time, want, mean_difference_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        take_pair(data_sample_i, ref_sample_i);
      pending_o <= mean_diff_q.size();
    end
  end

endmodule

FILE: verif/tb_switched_sync_detector.sv
module tb_switched_sync_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import sswd_pkg::*;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned MAX_WINDOW    = 4096;
  localparam int unsigned GAP_MAX       = 11;
  // one finished window may wait behind the one in work
  localparam int unsigned SETTLE_CYCLES = 256;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx     = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata   = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  data_sample = '0;
  logic signed [SAMPLE_W-1:0]  ref_sample  = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic signed [SAMPLE_W:0]    mean_difference;

  int                          pending;
  int                          fail_count;

  // Stimulus-side copy of the levels, used only to aim references at the threshold
  logic signed [SAMPLE_W-1:0]  hi_lvl      = HIGH_LEVEL_RST;
  logic signed [SAMPLE_W-1:0]  lo_lvl      = LOW_LEVEL_RST;

  // Calm flags switch off the random gaps on either side for a phase
  bit                          src_calm    = 1'b0;
  bit                          sink_calm   = 1'b0;

  int unsigned                 stall_left  = 0;
  int unsigned                 idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  switched_sync_detector #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_sample_i     (data_sample),
    .ref_sample_i      (ref_sample),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .mean_difference_o (mean_difference)
  );

  sswd_window_checker #(
    .MAX_WINDOW (MAX_WINDOW)
  ) window_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .data_sample_i     (data_sample),
    .ref_sample_i      (ref_sample),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .mean_difference_i (mean_difference),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Result sink: after each taken result (or while ready is low with no stall
  // running) draw a fresh stall; hold ready low until that stall has run out.
  always @(posedge clk) begin : sink
    int unsigned gap;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1)
        out_ready <= 1'b1;
    end else if (!out_ready || out_valid) begin
      gap = sink_calm ? 0 : $urandom_range(GAP_MAX, 0);
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= gap;
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one register write for one edge; the caller drops the enable after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    if (idx == REG_HIGH_LEVEL)
      hi_lvl = $signed(value);
    else if (idx == REG_LOW_LEVEL)
      lo_lvl = $signed(value);
    @(posedge clk);
  endtask

  // Offer one pair after a random gap and hold it until it is taken.
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] data,
                           input logic signed [SAMPLE_W-1:0] refv);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(GAP_MAX, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_sample <= data;
    ref_sample  <= refv;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every outstanding result, then let the back end go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_level();
    case ($urandom_range(7, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned                rand_items;
    int unsigned                pick;
    int                         near;
    logic signed [SAMPLE_W-1:0] d;
    logic signed [SAMPLE_W-1:0] r;
    rand_items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Window of one: each pair gives a result with the other class empty.
    // Hit the sample extremes and both sides of the default threshold.
    write_reg(REG_DECIM, 16'd1);
    cfg_we <= 1'b0;
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sd0, 16'sd16383);
    send_pair(-16'sd1, 16'sd16384);
    send_pair(16'sd1, 16'sd16385);
    settle();

    // A window length of zero behaves like one.
    write_reg(REG_DECIM, 16'd0);
    cfg_we <= 1'b0;
    send_pair(16'sd123, -16'sd5);
    send_pair(16'sh8000, 16'sd16383);
    settle();

    // Threshold at its floor (no wrap): everything lands in the high class and
    // a mean of -2/3 truncates to zero. Also poke the unused index.
    write_reg(REG_DECIM, 16'd3);
    write_reg(REG_HIGH_LEVEL, 16'h8000);
    write_reg(REG_LOW_LEVEL, 16'h7FFF);
    write_reg(REG_SPARE, 16'h1234);
    cfg_we <= 1'b0;
    send_pair(-16'sd1, 16'sh8000);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sh7FFF);
    settle();

    // Threshold at its ceiling: everything lands in the low class.
    write_reg(REG_DECIM, 16'd4);
    write_reg(REG_HIGH_LEVEL, 16'h7FFF);
    write_reg(REG_LOW_LEVEL, 16'h8000);
    cfg_we <= 1'b0;
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sd0);
    send_pair(16'sd5, 16'sh8000);
    settle();

    // Mixed window around a threshold of 200; the low mean is negative.
    write_reg(REG_HIGH_LEVEL, 16'd100);
    write_reg(REG_LOW_LEVEL, 16'hFF9C);
    cfg_we <= 1'b0;
    send_pair(16'sd7, 16'sd199);
    send_pair(16'sd8, 16'sd200);
    send_pair(-16'sd9, 16'sh8000);
    send_pair(16'sd10, 16'sh7FFF);
    settle();

    // Leave a window part full, then shorten it: the next pair must close it
    // with the sums kept across the write.
    write_reg(REG_DECIM, 16'd10);
    cfg_we <= 1'b0;
    repeat (6) send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    settle();
    write_reg(REG_DECIM, 16'd3);
    cfg_we <= 1'b0;
    send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));

    // Random phases. Each starts from a drained block, rewrites some registers
    // and pushes a burst of pairs, part of them aimed at the threshold.
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(1, 0) == 1) begin
        pick = $urandom_range(19, 0);
        if (pick == 0)
          write_reg(REG_DECIM, 16'd0);
        else if (pick < 4)
          write_reg(REG_DECIM, 16'd1);
        else
          write_reg(REG_DECIM, CFG_DATA_W'($urandom_range(64, 2)));
      end
      if ($urandom_range(1, 0) == 1)
        write_reg(REG_HIGH_LEVEL, rand_level());
      if ($urandom_range(1, 0) == 1)
        write_reg(REG_LOW_LEVEL, rand_level());
      if ($urandom_range(15, 0) == 0)
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      cfg_we   <= 1'b0;
      src_calm  = ($urandom_range(3, 0) == 0);
      sink_calm = ($urandom_range(3, 0) == 0);
      repeat ($urandom_range(100, 5)) begin
        case ($urandom_range(7, 0))
          0:       d = 16'sh8000;
          1:       d = 16'sh7FFF;
          default: d = SAMPLE_W'($urandom);
        endcase
        if ($urandom_range(3, 0) == 0) begin
          // aim within two of the threshold, clamped to the sample range
          near = int'(hi_lvl) - int'(lo_lvl) + int'($urandom_range(4, 0)) - 2;
          if (near > 32767)
            near = 32767;
          else if (near < -32768)
            near = -32768;
          r = SAMPLE_W'(near);
        end else begin
          r = SAMPLE_W'($urandom);
        end
        send_pair(d, r);
        rand_items++;
      end
    end

    // Drain: every expected result must arrive before the verdict.
    settle();
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
